// File: src/bbuf_pkg.sv
// ---------------------------------------------------------------------------
// bbuf_pkg: shared types and constants
// Field widths, the register reset value and the scan control bundle for the
// uniform block factor finder.
// ---------------------------------------------------------------------------
package bbuf_pkg;

  localparam int NIB_W       = 4;
  localparam int CFG_W       = 7;
  localparam int FACTOR_W    = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;

  // Control from the sequencer to the row check unit
  typedef struct packed {
    logic clear;        // restart the pass/fail accumulation
    logic row_valid;    // a row read from the bitmap RAM is on row_i
    logic block_first;  // that row is the top row of a block
  } scan_ctl_t;

endpackage

// File: src/bbuf_ram.sv
// ---------------------------------------------------------------------------
// bbuf_ram: generic RAM
// One write port with a bit write mask, one read port with registered data.
// ---------------------------------------------------------------------------
module bbuf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wmask_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < WIDTH; b++) begin
        if (wmask_i[b]) begin
          mem_q[waddr_i][b] <= wdata_i[b];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bbuf_scan_unit.sv
// ---------------------------------------------------------------------------
// bbuf_scan_unit: row check unit
// Checks one bitmap row per cycle, when row_valid is set, against the current block
// size: a block's top row must be constant inside each segment, later rows must equal it.
// ---------------------------------------------------------------------------
module bbuf_scan_unit #(
  parameter int WIDTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbuf_pkg::scan_ctl_t ctl_i,
  input  logic [WIDTH-1:0]    row_i,
  input  logic [WIDTH-1:0]    bnd_i,      // 1 at the first column of each segment
  input  logic [WIDTH-1:0]    colmask_i,  // 1 for columns inside the bitmap
  output logic                pass_o      // all rows so far, this one included, pass
);

  logic [WIDTH-1:0] ref_q;
  logic             ok_q;
  logic [WIDTH-1:0] hdiff;
  logic             row_ok;

  // neighbor difference, bit c compares column c with column c-1
  assign hdiff  = row_i ^ (row_i << 1);
  assign row_ok = ctl_i.block_first ? ~|(hdiff & ~bnd_i & colmask_i)
                                    : ~|((row_i ^ ref_q) & colmask_i);
  assign pass_o = ok_q & row_ok;

  always_ff @(posedge clk_i) begin
    if (ctl_i.row_valid && ctl_i.block_first) begin
      ref_q <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b1;
    end else if (ctl_i.clear) begin
      ok_q <= 1'b1;
    end else if (ctl_i.row_valid) begin
      ok_q <= pass_o;
    end
  end

endmodule

// File: src/bitmap_block_uniformity_factor_top.sv
// ---------------------------------------------------------------------------
// bitmap_block_uniformity_factor_top: largest uniform block factor
// Loads a square bitmap four pixels per item and reports the largest divisor
// of the side for which every aligned block is all zeros or all ones.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_we_i/cfg_wdata_i write side_length (reset 64); a write also restarts
//   loading at row 0. Write only while the block is idle.
//   Slave stream: one item per cycle while loading, pixel_nibble in tdata
//   (bit 3 leftmost pixel), tlast marks the last item of the bitmap. Items
//   past N*N/4 are dropped.
//   After a tlast item the scan runs and s_axis_tready_o is low. For each
//   candidate d from N down to 2, until one passes, the mask state builds
//   the segment mask and tests d | N; when d divides, the row state streams
//   rows through the row check unit. If none passes, the result is 1.
//   The result goes to an output register; loading of the next bitmap goes
//   on while it waits. If the receiver still stalls when the next scan ends,
//   the block holds in its done state until the register frees up.
//   Reset: side_length 64, load position 0, no result pending. Bitmap RAM
//   contents are not cleared.
// ---------------------------------------------------------------------------
module bitmap_block_uniformity_factor_top #(
  parameter int MAX_SIDE = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bbuf_pkg::CFG_W-1:0]           cfg_wdata_i,    // side_length
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [bbuf_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i, // [3:0] pixel_nibble
  input  logic                                 s_axis_tlast_i, // last_nibble
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [bbuf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o  // [6:0] block_factor
);

  localparam int AW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW       = $clog2(MAX_SIDE + 1);
  localparam int NW       = (AW > 2) ? AW - 2 : 1;
  localparam int SIDE_CAP = (MAX_SIDE / 4) * 4;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MASK = 2'd1;
  localparam logic [1:0] S_ROWS = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [bbuf_pkg::CFG_W-1:0]     side_q;
  logic [SW-1:0]                  row_q;
  logic [NW-1:0]                  cn_q;
  logic [SW-1:0]                  d_q;
  logic [AW-1:0]                  mc_q;
  logic [SW-1:0]                  mm_q;
  logic [SW-1:0]                  ra_q;
  logic                           iss_done_q;
  logic                           dv_q;
  logic                           dl_q;
  logic [SW-1:0]                  k_q;
  logic [MAX_SIDE-1:0]            bnd_q;
  logic [bbuf_pkg::FACTOR_W-1:0]  res_q;
  logic [bbuf_pkg::FACTOR_W-1:0]  out_q;
  logic                           out_valid_q;

  logic [bbuf_pkg::CFG_W-1:0]     side_masked;
  logic [SW-1:0]                  n_w;
  logic                           in_acc;
  logic                           load_en;
  logic                           nib_last;
  logic [AW-1:0]                  col;
  logic [bbuf_pkg::NIB_W-1:0]     nib;
  logic [bbuf_pkg::NIB_W-1:0]     rev;
  logic [MAX_SIDE-1:0]            wdata;
  logic [MAX_SIDE-1:0]            wmask;
  logic [MAX_SIDE-1:0]            colmask;
  logic [MAX_SIDE-1:0]            rdata;
  logic                           mask_end;
  logic                           divisible;
  logic                           rd_en;
  logic                           ra_last;
  logic                           pass;
  logic                           out_free;
  logic                           d_is_two;
  bbuf_pkg::scan_ctl_t            scan_ctl;

  // effective side: multiple of four, clamped to 4 .. SIDE_CAP
  assign side_masked = {side_q[bbuf_pkg::CFG_W-1:2], 2'b00};
  always_comb begin
    if (side_masked < 7'd4) begin
      n_w = SW'(4);
    end else if (32'(side_masked) > SIDE_CAP) begin
      n_w = SW'(SIDE_CAP);
    end else begin
      n_w = SW'(side_masked);
    end
  end

  for (genvar c = 0; c < MAX_SIDE; c++) begin : g_colmask
    assign colmask[c] = (32'(n_w) > c);
  end

  // loading
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign load_en  = in_acc & (row_q < n_w);
  assign nib_last = (32'(cn_q) == 32'(n_w >> 2) - 32'd1);
  assign col      = AW'({cn_q, 2'b00});
  assign nib      = s_axis_tdata_i[bbuf_pkg::NIB_W-1:0];
  assign rev      = {nib[0], nib[1], nib[2], nib[3]};
  assign wdata    = MAX_SIDE'(rev) << col;
  assign wmask    = MAX_SIDE'(4'hF) << col;

  // scan
  assign mask_end  = (state_q == S_MASK) && (32'(mc_q) == 32'(n_w) - 32'd1);
  assign divisible = (32'(mm_q) == 32'(d_q) - 32'd1);
  assign rd_en     = (state_q == S_ROWS) && !iss_done_q;
  assign ra_last   = (32'(ra_q) == 32'(n_w) - 32'd1);
  assign d_is_two  = (d_q == SW'(2));
  assign out_free  = !out_valid_q || m_axis_tready_i;

  assign scan_ctl.clear       = mask_end && divisible;
  assign scan_ctl.row_valid   = dv_q;
  assign scan_ctl.block_first = (k_q == '0);

  bbuf_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_en),
    .waddr_i (row_q[AW-1:0]),
    .wmask_i (wmask),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (ra_q[AW-1:0]),
    .rdata_o (rdata)
  );

  bbuf_scan_unit #(
    .WIDTH (MAX_SIDE)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .row_i     (rdata),
    .bnd_i     (bnd_q),
    .colmask_i (colmask),
    .pass_o    (pass)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && s_axis_tlast_i) state_d = S_MASK;
      end
      S_MASK: begin
        if (mask_end) begin
          if (divisible)     state_d = S_ROWS;
          else if (d_is_two) state_d = S_DONE;
        end
      end
      S_ROWS: begin
        if (dv_q && dl_q) begin
          if (pass || d_is_two) state_d = S_DONE;
          else                  state_d = S_MASK;
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      side_q      <= bbuf_pkg::SIDE_RESET;
      row_q       <= '0;
      cn_q        <= '0;
      d_q         <= '0;
      mc_q        <= '0;
      mm_q        <= '0;
      ra_q        <= '0;
      iss_done_q  <= 1'b0;
      dv_q        <= 1'b0;
      dl_q        <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= rd_en;
      dl_q    <= rd_en && ra_last;

      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
        row_q  <= '0;
        cn_q   <= '0;
      end else if (in_acc) begin
        if (s_axis_tlast_i) begin
          row_q <= '0;
          cn_q  <= '0;
        end else if (load_en) begin
          if (nib_last) begin
            cn_q  <= '0;
            row_q <= row_q + SW'(1);
          end else begin
            cn_q <= cn_q + NW'(1);
          end
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tlast_i) begin
            d_q  <= n_w;
            mc_q <= '0;
            mm_q <= '0;
          end
        end
        S_MASK: begin
          if (mask_end) begin
            if (divisible) begin
              ra_q       <= '0;
              iss_done_q <= 1'b0;
              k_q        <= '0;
            end else if (d_is_two) begin
              res_q <= bbuf_pkg::FACTOR_W'(1);
            end else begin
              d_q  <= d_q - SW'(1);
              mc_q <= '0;
              mm_q <= '0;
            end
          end else begin
            mc_q <= mc_q + AW'(1);
            mm_q <= divisible ? '0 : mm_q + SW'(1);
          end
        end
        S_ROWS: begin
          if (rd_en) begin
            ra_q <= ra_q + SW'(1);
            if (ra_last) iss_done_q <= 1'b1;
          end
          if (dv_q) begin
            k_q <= (32'(k_q) == 32'(d_q) - 32'd1) ? '0 : k_q + SW'(1);
            if (dl_q) begin
              if (pass) begin
                res_q <= bbuf_pkg::FACTOR_W'(d_q);
              end else if (d_is_two) begin
                res_q <= bbuf_pkg::FACTOR_W'(1);
              end else begin
                d_q  <= d_q - SW'(1);
                mc_q <= '0;
                mm_q <= '0;
              end
            end
          end
        end
        S_DONE: begin
        end
        default: begin
        end
      endcase

      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // segment start mask, one column per cycle in the mask state, and the result output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_MASK) begin
      bnd_q[mc_q] <= (mm_q == '0);
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = bbuf_pkg::OUT_TDATA_W'(out_q);

  // checks
  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_q != '0 && 32'(out_q) <= SIDE_CAP))
    else $error("block factor out of range");

  a_candidate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MASK || state_q == S_ROWS) |-> (d_q >= SW'(2) && d_q <= n_w))
    else $error("candidate block size out of range");

  a_mod_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MASK) |-> (mm_q < d_q))
    else $error("segment counter passed block size");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> $past(state_q) == S_ROWS)
    else $error("row data outside the row scan");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= n_w)
    else $error("load row passed the side length");

endmodule
